// ----- src/regex_class_expander_core_macros.svh -----
// assertion macros shared by the checker
`ifndef REGEX_CLASS_EXPANDER_CORE_MACROS_SVH
`define REGEX_CLASS_EXPANDER_CORE_MACROS_SVH

// property checked outside reset
`define RCE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every edge, reset included
`define RCE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/rce_pkg.sv -----
// package: byte codes, command type and helpers for the class expander
`default_nettype none
package rce_pkg;

   localparam int MAX_LEN_DEFAULT     = 256;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_DIGIT = 2'd1,
      KIND_UPPER = 2'd2,
      KIND_LOWER = 2'd3
   } kind_type;

   // one queued command: the result bytes one request produces
   typedef struct packed {
      logic       err;
      logic       bar;
      logic [1:0] cnt;
      logic [7:0] b0;
      logic [7:0] b1;
      logic       rng;
      logic [7:0] lo;
      logic [7:0] hi;
      logic       term;
   } cmd_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_BAR  = 8'b0000_0010,
      ST_B0   = 8'b0000_0100,
      ST_B1   = 8'b0000_1000,
      ST_RBAR = 8'b0001_0000,
      ST_RVAL = 8'b0010_0000,
      ST_TERM = 8'b0100_0000,
      ST_ERR  = 8'b1000_0000
   } stage_type;

   function automatic kind_type char_kind(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return KIND_DIGIT;
      if (c >= 8'h41 && c <= 8'h5A) return KIND_UPPER;
      if (c >= 8'h61 && c <= 8'h7A) return KIND_LOWER;
      return KIND_OTHER;
   endfunction

endpackage
`default_nettype wire

// ----- src/regex_class_expander_core.sv -----
// top level of the regex bracket class expander
// The block takes a regex one byte per request and returns the rewritten string
// one byte per response: '[' and ']' become '(' and ')', class members are joined
// by '|', ranges such as a-f are written out member by member, and '/' escapes
// the next byte. Every string ends in a terminator response (byte 0, last set);
// a malformed range, a dangling escape, range or class ends it instead in an
// error response (byte 0, last and error set), after which the rest of the
// string gives nothing. Bytes past MAX_LEN in a string are ignored. A request is
// taken whenever the command queue has room; the back end loads a command in
// its idle state and then emits one response byte per cycle while the response
// channel is not stalled; a range gives '|' and then the byte for each member.
// Bursts of up to QUEUE_DEPTH commands are absorbed while the back end is busy.
`default_nettype none
module regex_class_expander_core
   import rce_pkg::*;
#(
   parameter int MAX_LEN     = MAX_LEN_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_char,
   input  wire logic       req_in_last,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_out_last,
   output logic            rsp_out_error
);

   logic    q_full;
   logic    q_not_empty;
   logic    q_push;
   logic    q_pop;
   cmd_type front_cmd;
   cmd_type head_cmd;

   // accept whenever the queue has room; bytes with no output push nothing
   assign req_ready = !q_full;

   // parser state lives here
   rce_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_valid && req_ready),
      .in_char (req_in_char),
      .in_last (req_in_last),
      .push    (q_push),
      .cmd     (front_cmd)
   );

   // decouples parsing from the byte-serial emitter
   rce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (front_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_cmd)
   );

   // emitter with registered response outputs
   rce_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_not_empty),
      .q_cmd         (head_cmd),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_out_last  (rsp_out_last),
      .rsp_out_error (rsp_out_error)
   );

endmodule
`default_nettype wire

// ----- src/rce_front.sv -----
// front end: parses each request byte and builds a result command
`default_nettype none
module rce_front
   import rce_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_char,
   input  wire logic       in_last,
   output logic            push,
   output cmd_type         cmd
);

   localparam int CW = $clog2(MAX_LEN + 1);

   logic          inside_ff, inside_in;
   logic          member_ff, member_in;
   logic          esc_ff, esc_in;
   logic          rngp_ff, rngp_in;
   logic [7:0]    prev_ff, prev_in;
   logic          errs_ff, errs_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      logic perr;
      logic [7:0] c;
      c         = in_char;
      perr      = 1'b0;
      inside_in = inside_ff;
      member_in = member_ff;
      esc_in    = esc_ff;
      rngp_in   = rngp_ff;
      prev_in   = prev_ff;
      errs_in   = errs_ff;
      count_in  = count_ff;
      cmd       = '0;
      if (errs_ff) begin
         // discarding the rest of a failed string
      end else begin
         if (count_ff < CW'(MAX_LEN)) begin
            count_in = count_ff + 1'b1;
            if (esc_ff) begin
               esc_in  = 1'b0;
               cmd.cnt = 2'd2;
               cmd.b0  = CH_SLASH;
               cmd.b1  = c;
               if (inside_ff) begin
                  cmd.bar   = member_ff;
                  member_in = 1'b1;
                  prev_in   = c;
               end
            end else if (rngp_ff) begin
               rngp_in = 1'b0;
               if (char_kind(prev_ff) == KIND_OTHER || char_kind(prev_ff) != char_kind(c)
                   || prev_ff >= c) begin
                  perr = 1'b1;
               end else begin
                  cmd.rng = 1'b1;
                  cmd.lo  = prev_ff + 8'd1;
                  cmd.hi  = c;
                  prev_in = c;
               end
            end else if (c == CH_SLASH) begin
               esc_in = 1'b1;
            end else if (inside_ff) begin
               if (c == CH_RBRK) begin
                  cmd.cnt   = 2'd1;
                  cmd.b0    = CH_RPAR;
                  inside_in = 1'b0;
               end else if (c == CH_DASH) begin
                  if (!member_ff) perr = 1'b1;
                  else rngp_in = 1'b1;
               end else begin
                  cmd.bar   = member_ff;
                  cmd.cnt   = 2'd1;
                  cmd.b0    = c;
                  member_in = 1'b1;
                  prev_in   = c;
               end
            end else begin
               cmd.cnt = 2'd1;
               if (c == CH_LBRK) begin
                  cmd.b0    = CH_LPAR;
                  inside_in = 1'b1;
                  member_in = 1'b0;
               end else if (c == CH_RBRK) begin
                  cmd.b0 = CH_RPAR;
               end else begin
                  cmd.b0 = c;
               end
            end
         end
         if (perr) begin
            cmd     = '0;
            cmd.err = 1'b1;
            errs_in = 1'b1;
         end else if (in_last) begin
            if (inside_in || esc_in || rngp_in) begin
               cmd     = '0;
               cmd.err = 1'b1;
            end else begin
               cmd.term = 1'b1;
            end
         end
      end
      if (in_last) begin
         inside_in = 1'b0;
         member_in = 1'b0;
         esc_in    = 1'b0;
         rngp_in   = 1'b0;
         prev_in   = '0;
         errs_in   = 1'b0;
         count_in  = '0;
      end
   end

   assign push = accept && (cmd.err || cmd.bar || cmd.cnt != 2'd0 || cmd.rng || cmd.term);

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         member_ff <= 1'b0;
         esc_ff    <= 1'b0;
         rngp_ff   <= 1'b0;
         prev_ff   <= '0;
         errs_ff   <= 1'b0;
         count_ff  <= '0;
      end else if (accept) begin
         inside_ff <= inside_in;
         member_ff <= member_in;
         esc_ff    <= esc_in;
         rngp_ff   <= rngp_in;
         prev_ff   <= prev_in;
         errs_ff   <= errs_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/rce_queue.sv -----
// command queue between front and back end
`default_nettype none
module rce_queue
   import rce_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output cmd_type      head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type       slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == CW'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
   end

endmodule
`default_nettype wire

// ----- src/rce_back.sv -----
// back end: walks one command and emits its result bytes
`default_nettype none
module rce_back
   import rce_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire cmd_type    q_cmd,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_out_last,
   output logic            rsp_out_error
);

   stage_type  st_ff, st_in;
   cmd_type    cmd_ff, cmd_in;
   logic [7:0] val_ff, val_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       error_ff, error_in;
   logic       out_free;

   function automatic stage_type next_stage(input cmd_type c, input stage_type from);
      stage_type after_b1;
      stage_type after_b0;
      stage_type after_bar;
      after_b1  = c.rng ? ST_RBAR : (c.term ? ST_TERM : ST_IDLE);
      after_b0  = (c.cnt == 2'd2) ? ST_B1 : after_b1;
      after_bar = (c.cnt != 2'd0) ? ST_B0 : after_b1;
      case (from)
         ST_IDLE: return c.err ? ST_ERR : (c.bar ? ST_BAR : after_bar);
         ST_BAR:  return after_bar;
         ST_B0:   return after_b0;
         ST_B1:   return after_b1;
         default: return ST_IDLE;
      endcase
   endfunction

   assign out_free = !valid_ff || rsp_ready;
   assign pop      = (st_ff == ST_IDLE) && q_valid;

   always_comb begin
      st_in    = st_ff;
      cmd_in   = cmd_ff;
      val_in   = val_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      error_in = error_ff;
      if (st_ff == ST_IDLE) begin
         if (q_valid) begin
            cmd_in = q_cmd;
            val_in = q_cmd.lo;
            st_in  = next_stage(q_cmd, ST_IDLE);
         end
      end else if (out_free) begin
         valid_in = 1'b1;
         last_in  = 1'b0;
         error_in = 1'b0;
         st_in    = next_stage(cmd_ff, st_ff);
         case (st_ff)
            ST_BAR:  char_in = CH_BAR;
            ST_B0:   char_in = cmd_ff.b0;
            ST_B1:   char_in = cmd_ff.b1;
            ST_RBAR: begin
               char_in = CH_BAR;
               st_in   = ST_RVAL;
            end
            ST_RVAL: begin
               char_in = val_ff;
               val_in  = val_ff + 8'd1;
               st_in   = (val_ff == cmd_ff.hi) ? (cmd_ff.term ? ST_TERM : ST_IDLE) : ST_RBAR;
            end
            ST_TERM: begin
               char_in = CH_NUL;
               last_in = 1'b1;
            end
            ST_ERR: begin
               char_in  = CH_NUL;
               last_in  = 1'b1;
               error_in = 1'b1;
            end
            default: valid_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      val_ff   <= val_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_out_last  = last_ff;
   assign rsp_out_error = error_ff;

endmodule
`default_nettype wire

// ----- src/rce_checker.sv -----
// port checker for the class expander, bound to the top level
`default_nettype none
`include "regex_class_expander_core_macros.svh"
module rce_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_out_last,
   input wire logic       rsp_out_error
);

   // stalled response holds its bytes
   `RCE_ASSERT(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_out_last) && $stable(rsp_out_error),
      "response changed while stalled")

   // error response always closes the string with a null byte
   `RCE_ASSERT(a_err_last, rsp_valid && rsp_out_error |-> rsp_out_last && rsp_out_char == 8'h00, "error response malformed")

   // terminator carries a null byte
   `RCE_ASSERT(a_term_nul, rsp_valid && rsp_out_last |-> rsp_out_char == 8'h00, "last response not null")

   // nothing comes out right after reset
   `RCE_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind regex_class_expander_core rce_checker u_rce_checker (.*);
`default_nettype wire
